FILE: hdl/dpm_pkg.sv
`timescale 1ns / 1ps
package dpm_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int NFEAT = 5;
  localparam logic [15:0] STR_ONE = 16'd32768;
  localparam logic [15:0] STR_FLOOR = 16'd262;
  localparam logic [15:0] STR_BOOST = 16'd1966;
  localparam logic [15:0] STR_PLANT = 16'd2621;
  localparam logic [15:0] PULL_Q16 = 16'd5243;

  localparam logic [2:0] REG_THR = 3'd5;
  localparam logic [2:0] REG_DECAY = 3'd6;
  localparam logic [2:0] REG_TARGET = 3'd7;

  typedef struct packed {
    logic clear_acc;
    logic decay_slot;
    logic dist_slot;
    logic plant;
    logic take;
    logic apply;
    logic summary;
    logic [SW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic found;
  } status_t;
endpackage

FILE: hdl/dpm_ctrl.sv
`timescale 1ns / 1ps
module dpm_ctrl
  import dpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic mode,
  input  logic feature_valid,
  input  logic out_free,
  input  status_t status,
  output cmd_t cmd,
  output logic busy,
  output logic done
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECAY = 3'd1;
  localparam logic [2:0] S_DIST = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_SUM = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0] state, state_next;
  logic [SW-1:0] slot, slot_next;
  logic last;

  assign last = (slot == SW'(NUM_SLOTS - 1));
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    slot_next = slot;
    cmd = '0;
    cmd.slot = slot;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.clear_acc = 1'b1;
          slot_next = '0;
          if (mode) begin
            cmd.take = 1'b1;
            state_next = S_SUM;
          end else if (feature_valid) begin
            state_next = S_DECAY;
          end else begin
            state_next = S_SUM;
          end
        end
      end
      S_DECAY: begin
        cmd.decay_slot = 1'b1;
        slot_next = last ? '0 : slot + 1'b1;
        if (last) state_next = S_DIST;
      end
      S_DIST: begin
        cmd.dist_slot = 1'b1;
        slot_next = last ? '0 : slot + 1'b1;
        if (last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (status.found) cmd.apply = 1'b1;
        else cmd.plant = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.summary = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
    end else begin
      state <= state_next;
      slot <= slot_next;
    end
  end
endmodule

FILE: hdl/dpm_datapath.sv
`timescale 1ns / 1ps
module dpm_datapath
  import dpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic [NFEAT-1:0][15:0] x_in,
  input  logic x_load,
  input  logic [NFEAT-1:0][15:0] weights,
  input  logic [39:0] thr,
  input  logic [15:0] decay,
  input  logic [7:0] target,
  output status_t status,
  output logic [1:0] growth_state,
  output logic best_found,
  output logic [2:0] best_slot,
  output logic promoted,
  output logic [NFEAT-1:0][15:0] prom_c,
  output logic [7:0] taken_stability
);
  logic [NFEAT-1:0][15:0] centre [NUM_SLOTS];
  logic [15:0] strength [NUM_SLOTS];
  logic [7:0] stab [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active;
  logic pend;
  logic [SW-1:0] pidx;
  logic [NFEAT-1:0][15:0] x;
  logic [42:0] best_d;
  logic found;
  logic [SW-1:0] best;

  logic [31:0] dprod;
  logic [15:0] dec_s;
  logic [NFEAT-1:0][15:0] mag;
  logic [NFEAT-1:0][32:0] msq;
  logic [NFEAT-1:0][32:0] msq_r;
  logic dist_v;
  logic [SW-1:0] dist_idx;
  logic [NFEAT-1:0][40:0] term;
  logic [42:0] dsum;

  assign dprod = strength[cmd.slot] * decay;
  assign dec_s = dprod[31:16];

  // squares for the slot being walked
  always_comb begin
    for (int k = 0; k < NFEAT; k++) begin
      mag[k] = (x[k] >= centre[cmd.slot][k]) ? x[k] - centre[cmd.slot][k]
                                             : centre[cmd.slot][k] - x[k];
      msq[k] = 33'(mag[k]) * 33'(mag[k]);
    end
  end

  // weighted sum in the next cycle, from the registered squares
  always_comb begin
    dsum = '0;
    for (int k = 0; k < NFEAT; k++) begin
      term[k] = 41'((49'(msq_r[k]) * 49'(weights[k])) >> 8);
      dsum = dsum + 43'(term[k]);
    end
  end

  assign status.found = found;

  logic free_found;
  logic [SW-1:0] free_i, weak_i;
  always_comb begin
    free_found = 1'b0;
    free_i = '0;
    weak_i = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_i = SW'(i);
      end
    end
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (strength[i] < strength[weak_i]) weak_i = SW'(i);
    end
  end

  logic [NFEAT-1:0][15:0] pulled;
  logic [NFEAT-1:0][15:0] pmag;
  logic [NFEAT-1:0][32:0] pprod;
  logic [16:0] boosted;
  always_comb begin
    for (int k = 0; k < NFEAT; k++) begin
      pmag[k] = (x[k] >= centre[best][k]) ? x[k] - centre[best][k] : centre[best][k] - x[k];
      pprod[k] = 33'(pmag[k]) * 33'(PULL_Q16) + 33'd32768;
      pulled[k] = (x[k] >= centre[best][k]) ? centre[best][k] + pprod[k][31:16]
                                            : centre[best][k] - pprod[k][31:16];
    end
    boosted = {1'b0, strength[best]} + {1'b0, STR_BOOST};
  end

  logic [SW-1:0] ns;
  assign ns = free_found ? free_i : weak_i;

  logic take_ok;
  assign take_ok = cmd.take && pend && active[pidx] && (stab[pidx] >= target);

  logic any_a, stab_a, bf;
  logic [SW-1:0] bs;
  logic [15:0] bstr;
  always_comb begin
    any_a = 1'b0;
    stab_a = 1'b0;
    bf = 1'b0;
    bs = '0;
    bstr = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (active[i]) begin
        any_a = 1'b1;
        if (stab[i] >= (target >> 1)) stab_a = 1'b1;
        if (strength[i] > bstr) begin
          bstr = strength[i];
          bs = SW'(i);
          bf = 1'b1;
        end
      end
    end
  end

  logic [7:0] stab_inc;
  assign stab_inc = (stab[best] != 8'd255) ? stab[best] + 8'd1 : stab[best];

  always_ff @(posedge clk) begin
    if (x_load) x <= x_in;
    msq_r <= msq;
    dist_v <= !rst && cmd.dist_slot && active[cmd.slot];
    dist_idx <= cmd.slot;
    if (cmd.clear_acc) begin
      best_d <= {3'b0, thr};
      found <= 1'b0;
      best <= '0;
      promoted <= take_ok;
      prom_c <= take_ok ? centre[pidx] : '0;
      taken_stability <= take_ok ? stab[pidx] : 8'd0;
    end
    if (dist_v && dsum < best_d) begin
      best_d <= dsum;
      best <= dist_idx;
      found <= 1'b1;
    end
    if (cmd.summary) begin
      growth_state <= pend ? 2'd3 : stab_a ? 2'd2 : any_a ? 2'd1 : 2'd0;
      best_found <= bf;
      best_slot <= 3'(bs);
    end
    if (rst) begin
      active <= '0;
      pend <= 1'b0;
      pidx <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        centre[i] <= '0;
        strength[i] <= '0;
        stab[i] <= '0;
      end
    end else begin
      if (cmd.decay_slot && active[cmd.slot]) begin
        strength[cmd.slot] <= dec_s;
        if (dec_s < STR_FLOOR) begin
          active[cmd.slot] <= 1'b0;
          if (pend && pidx == cmd.slot) pend <= 1'b0;
        end
      end
      if (cmd.apply) begin
        centre[best] <= pulled;
        strength[best] <= (boosted > {1'b0, STR_ONE}) ? STR_ONE : boosted[15:0];
        stab[best] <= stab_inc;
        if (stab_inc >= target) begin
          pend <= 1'b1;
          pidx <= best;
        end
      end
      if (cmd.plant) begin
        centre[ns] <= x;
        stab[ns] <= 8'd1;
        strength[ns] <= STR_PLANT;
        active[ns] <= 1'b1;
        if (pend && pidx == ns) pend <= 1'b0;
      end
      if (cmd.take && pend) begin
        pend <= 1'b0;
        if (take_ok) begin
          centre[pidx] <= '0;
          strength[pidx] <= '0;
          stab[pidx] <= '0;
          active[pidx] <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: hdl/decaying_prototype_matcher_top.sv
`timescale 1ns / 1ps
// decaying prototype matcher: a table of eight feature prototypes with decay
// input channel: valid/ready with mode, feature_valid and five Q0.16 features;
// one request in gives exactly one result on the output valid/ready channel
// an update request walks every slot for decay, then every slot for distance,
// then a flush step finishes the last distance, then apply or plant, summary
// and the output load; the next request can be accepted once it is back idle.
// check and ignored updates skip both walks and go to summary and the output
// load. one request is worked at a time; ready is high only while idle
// the result sits in an output register until taken; while the receiver
// stalls one more request can be accepted and worked, its result then waits
// inside and no further request is accepted
// configuration by an APB-style port at byte address 8*i; the user writes it
// only while idle, which the block does not enforce
// reset clears all slots and promotion state and sets the configuration
// registers to defaults
module decaying_prototype_matcher_top
  import dpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic mode,
  input  logic feature_valid,
  input  logic [15:0] rms_in,
  input  logic [15:0] variance_in,
  input  logic [15:0] hum_in,
  input  logic [15:0] texture_in,
  input  logic [15:0] transient_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] growth_state,
  output logic best_found,
  output logic [2:0] best_slot,
  output logic promoted,
  output logic [15:0] promoted_rms,
  output logic [15:0] promoted_variance,
  output logic [15:0] promoted_hum,
  output logic [15:0] promoted_texture,
  output logic [15:0] promoted_transient,
  output logic [7:0] taken_stability,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [5:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  logic [NFEAT-1:0][15:0] w;
  logic [39:0] thr;
  logic [15:0] decay;
  logic [7:0] target;
  logic [2:0] ridx;
  logic wr, busy, done, in_fire;
  cmd_t cmd;
  status_t status;
  logic [NFEAT-1:0][15:0] pc;
  logic [1:0] r_growth;
  logic r_found;
  logic [2:0] r_slot;
  logic r_promoted;
  logic [7:0] r_stab;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NFEAT; k++) w[k] <= 16'd256;
      thr <= 40'd1073741824;
      decay <= 16'd64880;
      target <= 8'd20;
    end else if (wr) begin
      case (ridx)
        REG_THR: thr <= pwdata[39:0];
        REG_DECAY: decay <= pwdata[15:0];
        REG_TARGET: target <= pwdata[7:0];
        default: w[ridx] <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_THR: prdata = {24'd0, thr};
      REG_DECAY: prdata = {48'd0, decay};
      REG_TARGET: prdata = {56'd0, target};
      default: prdata = {48'd0, w[ridx]};
    endcase
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  dpm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .mode(mode),
    .feature_valid(feature_valid), .out_free(!out_valid || out_ready),
    .status(status), .cmd(cmd), .busy(busy), .done(done)
  );

  dpm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .x_in({transient_in, texture_in, hum_in, variance_in, rms_in}),
    .x_load(in_fire), .weights(w), .thr(thr), .decay(decay), .target(target),
    .status(status), .growth_state(r_growth), .best_found(r_found),
    .best_slot(r_slot), .promoted(r_promoted), .prom_c(pc),
    .taken_stability(r_stab)
  );

  // result register
  always_ff @(posedge clk) begin
    if (done) begin
      growth_state <= r_growth;
      best_found <= r_found;
      best_slot <= r_slot;
      promoted <= r_promoted;
      promoted_rms <= pc[0];
      promoted_variance <= pc[1];
      promoted_hum <= pc[2];
      promoted_texture <= pc[3];
      promoted_transient <= pc[4];
      taken_stability <= r_stab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("request not taken");
  a_promote_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !promoted) |-> (taken_stability == 8'd0))
    else $error("stale promotion data");
endmodule
